FILE: hw/rtl/srfp_pkg.sv
// Shared types and constants of the servo reply frame parser.
// No dependencies; the item and result interfaces and the top level take it in.
`timescale 1ns / 1ps
`default_nettype none

package srfp_pkg;

    // Payload buffer depth in bytes
    localparam int MAX_PARAMS = 32;
    localparam int ADDR_W     = $clog2(MAX_PARAMS);
    // Raw byte index runs up to 3 + LEN with LEN at most MAX_PARAMS + 2
    localparam int BT_W       = $clog2(MAX_PARAMS + 6);

    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 6;
    localparam int STATUS_W = 3;
    localparam int TICK_W   = 16;

    localparam logic [BYTE_W-1:0] HDR_BYTE      = 8'hFF;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd20;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_BAD_SUM   = 3'd2,
        ST_OTHER_ID  = 3'd3,
        ST_TOO_MANY  = 3'd4,
        ST_CUT_SHORT = 3'd5,
        ST_NONE      = 3'd6,
        ST_UNUSED    = 3'd7
    } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srfp_item_if.sv
// Input item channel of the servo reply frame parser: valid/ready and item fields.
// Depends on srfp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface srfp_item_if;
    logic                          valid;
    logic                          ready;
    logic [srfp_pkg::KIND_W-1:0]   kind;
    logic [srfp_pkg::BYTE_W-1:0]   expected_id;
    logic [srfp_pkg::CNT_W-1:0]    max_params;
    logic [srfp_pkg::BYTE_W-1:0]   bus_byte;

    modport source (output valid, kind, expected_id, max_params, bus_byte, input ready);
    modport sink   (input valid, kind, expected_id, max_params, bus_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/srfp_result_if.sv
// Result channel of the servo reply frame parser: valid/ready and result fields.
// Depends on srfp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface srfp_result_if;
    logic                           valid;
    logic                           ready;
    logic [srfp_pkg::STATUS_W-1:0]  status;
    logic [srfp_pkg::BYTE_W-1:0]    servo_error;
    logic [srfp_pkg::CNT_W-1:0]     payload_count;
    logic [srfp_pkg::BYTE_W-1:0]    payload_byte;
    logic                           last;

    modport source (output valid, status, servo_error, payload_count, payload_byte, last,
                    input ready);
    modport sink   (input valid, status, servo_error, payload_count, payload_byte, last,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/srfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module srfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/servo_reply_frame_parser_unit.sv
// Top level of the servo reply frame parser: header hunt, checks, timeout, result runs.
// Depends on srfp_pkg, srfp_item_if, srfp_result_if and srfp_ram.
//
//   channel   direction  handshake      payload
//   item      in         valid/ready    kind, expected_id, max_params, bus_byte
//   result    out        valid/ready    status, servo_error, payload_count,
//                                       payload_byte, last
//   cfg       in         cfg_we only    cfg_wdata = timeout_ticks
//
// An item is first captured, then decoded and the frame state updated. A good
// reply with n payload bytes then streams out at one byte per cycle, while result.ready
// holds, from the payload RAM, whose registered read port sets that pace.
// Reset clears all control state and loads a timeout of 20 ticks; the payload RAM
// is not cleared. A stalled result register holds the block in the decode or
// readout step; it is released the cycle result.ready returns.
`timescale 1ns / 1ps
`default_nettype none

module servo_reply_frame_parser_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    srfp_item_if.sink                          item,
    srfp_result_if.source                      result,
    input  wire logic                          cfg_we,
    input  wire logic [srfp_pkg::TICK_W-1:0]   cfg_wdata
);

    import srfp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    // Control and sequencing
    state_t              state_reg, state_next;
    logic [TICK_W-1:0]   timeout_reg;

    // Captured item
    kind_t               kind_reg;
    logic [BYTE_W-1:0]   eid_reg;
    logic [CNT_W-1:0]    maxp_reg;
    logic [BYTE_W-1:0]   byte_reg;

    // Frame state
    logic                armed_reg, armed_next;
    logic                in_frame_reg, in_frame_next;
    logic [BT_W-1:0]     bt_reg, bt_next;
    logic [BYTE_W-1:0]   len_reg, len_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic [BYTE_W-1:0]   rid_reg, rid_next;
    logic [BYTE_W-1:0]   rerr_reg, rerr_next;
    logic [BYTE_W-1:0]   want_id_reg, want_id_next;
    logic [CNT_W-1:0]    want_max_reg, want_max_next;
    logic [TICK_W-1:0]   elapsed_reg, elapsed_next;

    // Readout run
    logic [CNT_W-1:0]    run_count_reg, run_count_next;
    logic [BYTE_W-1:0]   run_err_reg, run_err_next;
    logic [ADDR_W-1:0]   run_idx_reg, run_idx_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [BYTE_W-1:0]   out_serr_reg, out_serr_next;
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;

    // Payload RAM access
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;

    // Decode results
    logic                out_free;
    logic                fin;          // item ends the hunt with a single result
    status_t             fin_status;
    logic [BYTE_W-1:0]   fin_serr;
    logic                run_go;       // item ends the hunt with a payload run
    logic                do_complete;
    logic [BYTE_W-1:0]   cmp_len;
    logic [BYTE_W-1:0]   cmp_count;
    logic [TICK_W-1:0]   tick_inc;
    logic                run_last;

    assign item.ready  = (state_reg == S_IDLE);
    assign out_free    = !out_valid_reg || result.ready;
    assign run_last    = ((CNT_W'(run_idx_reg) + CNT_W'(1)) == run_count_reg);
    assign tick_inc    = (elapsed_reg != TICK_MAX) ? elapsed_reg + TICK_W'(1) : elapsed_reg;
    // LEN byte itself closes the frame when LEN is zero
    assign cmp_len     = (bt_reg == BT_W'(3)) ? byte_reg : len_reg;
    assign cmp_count   = cmp_len - BYTE_W'(2);

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.servo_error   = out_serr_reg;
    assign result.payload_count = out_cnt_reg;
    assign result.payload_byte  = out_byte_reg;
    assign result.last          = out_last_reg;

    srfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PARAMS)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode the captured item against the frame state: what ends the hunt and how.
    always_comb
    begin
        fin         = 1'b0;
        fin_status  = ST_OK;
        fin_serr    = '0;
        run_go      = 1'b0;
        do_complete = 1'b0;

        if (armed_reg && kind_reg == KIND_BYTE && in_frame_reg)
        begin
            if (bt_reg == BT_W'(3))
            begin
                if (byte_reg == '0)
                begin
                    do_complete = 1'b1;
                end
                else if (9'(byte_reg) > 9'(MAX_PARAMS + 2))
                begin
                    fin        = 1'b1;
                    fin_status = ST_TOO_LONG;
                end
            end
            else if (bt_reg != BT_W'(2))
            begin
                do_complete = (9'(bt_reg) + 9'd1 >= 9'(len_reg) + 9'd4);
            end
        end

        if (do_complete)
        begin
            // Check order: checksum, id, short LEN, payload limit
            priority if (~sum_reg != byte_reg)
            begin
                fin        = 1'b1;
                fin_status = ST_BAD_SUM;
            end
            else if (rid_reg != want_id_reg)
            begin
                fin        = 1'b1;
                fin_status = ST_OTHER_ID;
            end
            else if (cmp_len < BYTE_W'(2))
            begin
                fin        = 1'b1;
                fin_status = ST_TOO_MANY;
            end
            else if (cmp_count > BYTE_W'(want_max_reg) || cmp_count > BYTE_W'(MAX_PARAMS))
            begin
                fin        = 1'b1;
                fin_status = ST_TOO_MANY;
                fin_serr   = rerr_reg;
            end
            else if (cmp_count == '0)
            begin
                fin        = 1'b1;
                fin_status = ST_OK;
                fin_serr   = rerr_reg;
            end
            else
            begin
                run_go = 1'b1;
            end
        end

        if (armed_reg && kind_reg == KIND_TICK && tick_inc >= timeout_reg)
        begin
            fin        = 1'b1;
            fin_status = (bt_reg != '0) ? ST_CUT_SHORT : ST_NONE;
        end
    end

    // Sequencer and read-modify-write of the frame state.
    always_comb
    begin
        state_next      = state_reg;
        armed_next      = armed_reg;
        in_frame_next   = in_frame_reg;
        bt_next         = bt_reg;
        len_next        = len_reg;
        sum_next        = sum_reg;
        rid_next        = rid_reg;
        rerr_next       = rerr_reg;
        want_id_next    = want_id_reg;
        want_max_next   = want_max_reg;
        elapsed_next    = elapsed_reg;
        run_count_next  = run_count_reg;
        run_err_next    = run_err_reg;
        run_idx_next    = run_idx_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_serr_next   = out_serr_reg;
        out_cnt_next    = out_cnt_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = ADDR_W'(bt_reg - BT_W'(5));
        ram_re          = 1'b0;
        ram_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // A single result waits here until the result register frees up
                if (!(fin && !out_free))
                begin
                    state_next = S_IDLE;

                    unique case (kind_reg)
                        KIND_START:
                        begin
                            armed_next    = 1'b1;
                            want_id_next  = eid_reg;
                            want_max_next = maxp_reg;
                        end
                        KIND_BYTE:
                        begin
                            if (armed_reg)
                            begin
                                priority if (!in_frame_reg)
                                begin
                                    if (byte_reg == HDR_BYTE)
                                    begin
                                        if (bt_reg != '0)
                                        begin
                                            bt_next       = BT_W'(2);
                                            in_frame_next = 1'b1;
                                        end
                                        else
                                        begin
                                            bt_next = BT_W'(1);
                                        end
                                    end
                                    else
                                    begin
                                        bt_next = '0;
                                    end
                                end
                                else if (bt_reg == BT_W'(2))
                                begin
                                    rid_next = byte_reg;
                                    sum_next = byte_reg;
                                    bt_next  = BT_W'(3);
                                end
                                else if (bt_reg == BT_W'(3))
                                begin
                                    len_next = byte_reg;
                                    bt_next  = BT_W'(4);
                                    sum_next = sum_reg + byte_reg;
                                end
                                else
                                begin
                                    if (bt_reg == BT_W'(4))
                                    begin
                                        rerr_next = byte_reg;
                                    end
                                    else if (9'(bt_reg) < 9'(MAX_PARAMS + 5))
                                    begin
                                        ram_we = !do_complete;
                                    end
                                    sum_next = sum_reg + byte_reg;
                                    bt_next  = bt_reg + BT_W'(1);
                                end
                            end
                        end
                        KIND_TICK:
                        begin
                            if (armed_reg)
                            begin
                                elapsed_next = tick_inc;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // Start, or any ending, drops the frame state
                    if (kind_reg == KIND_START || fin || run_go)
                    begin
                        in_frame_next = 1'b0;
                        bt_next       = '0;
                        len_next      = '0;
                        sum_next      = '0;
                        rid_next      = '0;
                        rerr_next     = '0;
                        elapsed_next  = '0;
                    end
                    if (fin || run_go)
                    begin
                        armed_next = 1'b0;
                    end

                    if (fin)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = fin_status;
                        out_serr_next   = fin_serr;
                        out_cnt_next    = '0;
                        out_byte_next   = '0;
                        out_last_next   = 1'b1;
                    end

                    if (run_go)
                    begin
                        run_count_next = CNT_W'(cmp_count);
                        run_err_next   = rerr_reg;
                        run_idx_next   = '0;
                        ram_re         = 1'b1;
                        ram_raddr      = '0;
                        state_next     = S_READ;
                    end
                end
            end

            S_READ:
            begin
                // RAM data for run_idx is ready; hold it until the slot frees
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_serr_next   = run_err_reg;
                    out_cnt_next    = run_count_reg;
                    out_byte_next   = ram_rdata;
                    out_last_next   = run_last;
                    if (run_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        run_idx_next = run_idx_reg + ADDR_W'(1);
                        ram_re       = 1'b1;
                        ram_raddr    = run_idx_reg + ADDR_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            timeout_reg   <= TIMEOUT_RESET;
            armed_reg     <= 1'b0;
            in_frame_reg  <= 1'b0;
            bt_reg        <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            rid_reg       <= '0;
            rerr_reg      <= '0;
            want_id_reg   <= '0;
            want_max_reg  <= '0;
            elapsed_reg   <= '0;
            run_count_reg <= '0;
            run_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            armed_reg     <= armed_next;
            in_frame_reg  <= in_frame_next;
            bt_reg        <= bt_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            rid_reg       <= rid_next;
            rerr_reg      <= rerr_next;
            want_id_reg   <= want_id_next;
            want_max_reg  <= want_max_next;
            elapsed_reg   <= elapsed_next;
            run_count_reg <= run_count_next;
            run_idx_reg   <= run_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: captured item, run error byte and result fields
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            kind_reg <= kind_t'(item.kind);
            eid_reg  <= item.expected_id;
            maxp_reg <= item.max_params;
            byte_reg <= item.bus_byte;
        end
        run_err_reg    <= run_err_next;
        out_status_reg <= out_status_next;
        out_serr_reg   <= out_serr_next;
        out_cnt_reg    <= out_cnt_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
    end

    // The payload RAM is only written while decoding a byte item
    a_ram_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EXEC && kind_reg == KIND_BYTE && armed_reg))
        else $error("payload RAM written outside byte decode");

    // A readout run always stays inside the stored payload
    a_run_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (CNT_W'(run_idx_reg) < run_count_reg && !armed_reg))
        else $error("readout index beyond run length");

    // Any non-ok result is a lone final transfer with no payload
    a_error_is_lone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK)
            |-> (out_last_reg && out_cnt_reg == '0 && out_byte_reg == '0))
        else $error("error result carries payload");

    // The last transfer of a run returns the sequencer to idle
    a_run_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && out_free && run_last) |=> (state_reg == S_IDLE))
        else $error("readout did not end after last byte");

endmodule

`default_nettype wire
